>>> src/bhgt_pkg.sv
// ----------------------------------------------------------------------------
// bhgt_pkg: shared types and constants of the bone hierarchy transform core
// Word layouts of both channels, fixed-point settings and status codes.
// ----------------------------------------------------------------------------
package bhgt_pkg;

    localparam int MAX_BONES = 64;
    localparam int FRAC_BITS = 16;

    localparam int BONE_W = $clog2(MAX_BONES);
    // Wide enough to hold a parent index, a bone index and MAX_BONES itself.
    localparam int CMP_W  = (BONE_W + 1 > 6) ? BONE_W + 1 : 6;
    localparam int ADDR_W = BONE_W + 3;
    localparam int NWORDS = 8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LATE = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic        first_of_pass;
        logic        is_root;
        logic [5:0]  parent_index;
        logic [63:0] local_r0_c01;
        logic [63:0] local_r0_c23;
        logic [63:0] local_r1_c01;
        logic [63:0] local_r1_c23;
        logic [63:0] local_r2_c01;
        logic [63:0] local_r2_c23;
        logic [63:0] local_r3_c01;
        logic [63:0] local_r3_c23;
    } t_bone_in;

    typedef struct packed {
        logic [5:0]  bone_index;
        logic [63:0] global_r0_c01;
        logic [63:0] global_r0_c23;
        logic [63:0] global_r1_c01;
        logic [63:0] global_r1_c23;
        logic [63:0] global_r2_c01;
        logic [63:0] global_r2_c23;
        logic [63:0] global_r3_c01;
        logic [63:0] global_r3_c23;
        logic [1:0]  status;
    } t_bone_out;

endpackage

>>> src/bhgt_if.sv
// ----------------------------------------------------------------------------
// bhgt interfaces: valid/ready channels of the bone hierarchy transform core
// One interface for incoming bone words and one for global matrix words.
// ----------------------------------------------------------------------------
interface bhgt_in_if import bhgt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_bone_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bhgt_out_if import bhgt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_bone_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/bhgt_ram.sv
// ----------------------------------------------------------------------------
// bhgt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bhgt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bone_hierarchy_global_transform_core.sv
// ----------------------------------------------------------------------------
// bone_hierarchy_global_transform_core: forward kinematics over a bone tree
// Multiplies each bone's local 4x4 Q16.16 matrix by its parent's global matrix.
// ----------------------------------------------------------------------------
// One bone word is taken at a time. A root, or a bone whose parent entry has
// never been written in the store (it reads as identity), has its local matrix
// copied and written to the store word by word. For any other bone, for each
// of the four rows, two store reads fetch the parent row, then one shared 32x32
// multiplier runs 16 multiply-accumulates in sequence, 64 products in all. A
// bone taken once the count is full is not written to the store. Store entries
// carry a valid bit that reset clears, so no clearing pass follows reset. The
// block takes the next bone while the previous result word still waits.
module bone_hierarchy_global_transform_core
    import bhgt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bhgt_in_if.sink    i_bone,
    bhgt_out_if.source o_global
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD0   = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_MAC   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] half_sel(input logic [63:0] w, input logic hi);
        return hi ? w[63:32] : w[31:0];
    endfunction

    logic [2:0]              r_state;
    logic [BONE_W-1:0]       r_cnt;
    logic                    r_full;
    logic [MAX_BONES-1:0]    r_vld;
    logic [BONE_W-1:0]       r_idx;
    logic [BONE_W-1:0]       r_pidx;
    logic                    r_late;
    logic                    r_over;
    logic                    r_sat;
    logic [1:0]              r_row;
    logic [3:0]              r_step;
    logic [3:0]              r_pstep;
    logic                    r_pv;
    logic [2:0]              r_wi;
    logic [63:0]             r_a0;
    logic [63:0]             r_a1;
    logic [63:0]             r_loc [NWORDS];
    logic [63:0]             r_res [NWORDS];
    logic signed [63:0]      r_prod;
    logic signed [63:0]      r_acc;
    logic                    r_ovalid;
    t_bone_out               r_out;

    // Accept-time decode.
    logic                    accept;
    logic                    full_eff;
    logic [BONE_W-1:0]       idx;
    logic [CMP_W-1:0]        pidx_ext;
    logic                    par_ok;
    logic [63:0]             in_words [NWORDS];

    // Multiply-accumulate datapath.
    logic signed [31:0]      a_el;
    logic signed [31:0]      b_el;
    logic signed [63:0]      sum;
    logic signed [31:0]      clamped;
    logic                    sat_now;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [63:0]             ram_rdata;
    logic [1:0]              status;

    assign i_bone.ready = (r_state == S_IDLE);
    assign accept       = i_bone.valid && i_bone.ready;

    assign full_eff = !i_bone.payload.first_of_pass && r_full;
    assign idx      = full_eff ? BONE_W'(MAX_BONES - 1)
                    : (i_bone.payload.first_of_pass ? '0 : r_cnt);
    assign pidx_ext = CMP_W'(i_bone.payload.parent_index);
    assign par_ok   = (pidx_ext < CMP_W'(MAX_BONES)) && r_vld[pidx_ext[BONE_W-1:0]];

    assign in_words[0] = i_bone.payload.local_r0_c01;
    assign in_words[1] = i_bone.payload.local_r0_c23;
    assign in_words[2] = i_bone.payload.local_r1_c01;
    assign in_words[3] = i_bone.payload.local_r1_c23;
    assign in_words[4] = i_bone.payload.local_r2_c01;
    assign in_words[5] = i_bone.payload.local_r2_c23;
    assign in_words[6] = i_bone.payload.local_r3_c01;
    assign in_words[7] = i_bone.payload.local_r3_c23;

    // Step bits: column in [3:2], inner index k in [1:0].
    assign a_el = half_sel(r_step[1] ? r_a1 : r_a0, r_step[0]);
    assign b_el = half_sel(r_loc[{r_step[1:0], r_step[3]}], r_step[2]);

    always_comb begin
        sum = ((r_pstep[1:0] == 2'd0) ? 64'sd0 : r_acc) + (r_prod >>> FRAC_BITS);
        sat_now = 1'b0;
        clamped = sum[31:0];
        if (sum > SAT_MAX) begin
            clamped = SAT_MAX[31:0];
            sat_now = 1'b1;
        end else if (sum < SAT_MIN) begin
            clamped = SAT_MIN[31:0];
            sat_now = 1'b1;
        end
    end

    assign ram_we    = (r_state == S_WR);
    assign ram_waddr = {r_idx, r_wi};
    assign ram_raddr = {r_pidx, r_row, (r_state == S_RD1)};

    bhgt_ram #(
        .WIDTH (64),
        .DEPTH (MAX_BONES * NWORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_res[r_wi]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        priority if (r_over) begin
            status = ST_FULL;
        end else if (r_late) begin
            status = ST_LATE;
        end else if (r_sat) begin
            status = ST_SAT;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_full   <= 1'b0;
            r_vld    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded below instead.
            if (o_global.valid && o_global.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx  <= idx;
                        r_pidx <= pidx_ext[BONE_W-1:0];
                        r_late <= !i_bone.payload.is_root && (pidx_ext >= CMP_W'(idx));
                        r_over <= full_eff;
                        r_sat  <= 1'b0;
                        r_row  <= '0;
                        r_wi   <= '0;
                        r_loc  <= in_words;
                        r_res  <= in_words;
                        if (!full_eff) begin
                            r_full <= (idx == BONE_W'(MAX_BONES - 1));
                            if (idx != BONE_W'(MAX_BONES - 1)) begin
                                r_cnt <= idx + 1'b1;
                            end
                        end
                        // An unwritten parent is identity, whose product is the local matrix.
                        if (i_bone.payload.is_root || !par_ok) begin
                            r_state <= full_eff ? S_DONE : S_WR;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_a0    <= ram_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_a1    <= ram_rdata;
                    r_step  <= '0;
                    r_state <= S_MAC;
                end
                S_MAC, S_DRAIN: begin
                    if (r_pv) begin
                        r_acc <= sum;
                        if (r_pstep[1:0] == 2'd3) begin
                            if (r_pstep[2]) begin
                                r_res[{r_row, r_pstep[3]}][63:32] <= clamped;
                            end else begin
                                r_res[{r_row, r_pstep[3]}][31:0] <= clamped;
                            end
                            r_sat <= r_sat || sat_now;
                        end
                    end
                    if (r_state == S_MAC) begin
                        r_prod  <= a_el * b_el;
                        r_pstep <= r_step;
                        r_pv    <= 1'b1;
                        r_step  <= r_step + 1'b1;
                        if (r_step == 4'd15) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_pv <= 1'b0;
                        if (r_row == 2'd3) begin
                            r_state <= r_over ? S_DONE : S_WR;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_RD0;
                        end
                    end
                end
                S_WR: begin
                    r_wi <= r_wi + 1'b1;
                    if (r_wi == 3'd7) begin
                        r_vld[r_idx] <= 1'b1;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_global.ready) begin
                        r_ovalid <= 1'b1;
                        r_out    <= '{
                            bone_index:    6'(r_idx),
                            global_r0_c01: r_res[0],
                            global_r0_c23: r_res[1],
                            global_r1_c01: r_res[2],
                            global_r1_c23: r_res[3],
                            global_r2_c01: r_res[4],
                            global_r2_c23: r_res[5],
                            global_r3_c01: r_res[6],
                            global_r3_c23: r_res[7],
                            status:        status
                        };
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_global.valid   = r_ovalid;
    assign o_global.payload = r_out;

    // A pending product exists only while the multiplier loop runs.
    a_pv_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_MAC || r_state == S_DRAIN))
        else $error("product pending outside the multiply loop");

    // Overflowed bones always report the last index.
    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_global.valid && o_global.payload.status == ST_FULL)
            |-> (o_global.payload.bone_index == 6'(MAX_BONES - 1)))
        else $error("count-exceeded word carries the wrong bone index");

    // The count stays full until a new pass starts.
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !(accept && i_bone.payload.first_of_pass)) |=> r_full)
        else $error("bone count full flag dropped within a pass");

endmodule
